### rtl/core/slie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slie_pkg: shared types and codes for the ordered list with extract-minimum
// Action and status codes, and the scan token that travels along the cells.
// ----------------------------------------------------------------------------
package slie_pkg;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_EXTRACT = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // minimum search token; the index of the best entry travels beside it
  typedef struct packed {
    logic        vld;
    logic [31:0] best;
    logic [31:0] last;
  } scan_tok_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        wb;
    logic [31:0] data;
  } cell_ctrl_t;

endpackage

### rtl/core/slie_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slie_cell: one slot of the list
// Holds one entry, takes its lower neighbour's entry on an insert shift, and
// updates the passing minimum-search token with its own entry.
// ----------------------------------------------------------------------------
module slie_cell
  import slie_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IDX      = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic [$clog2(CAPACITY+1)-1:0] ins_pos,
  input  logic [$clog2(CAPACITY)-1:0]   wb_idx,
  input  logic [31:0]                   prev_entry,
  output logic [31:0]                   entry,
  input  scan_tok_t                     tok_in,
  input  logic [$clog2(CAPACITY)-1:0]   idx_in,
  output scan_tok_t                     tok_out,
  output logic [$clog2(CAPACITY)-1:0]   idx_out
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] MY_CNT  = CW'(IDX);
  localparam logic [CW-1:0] MY_LAST = CW'(IDX + 1);
  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);

  logic in_list;
  logic take;

  assign in_list = (MY_CNT < count);
  assign take    = in_list && ((IDX == 0) || ($signed(entry) < $signed(tok_in.best)));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_CNT == ins_pos) begin
        entry <= ctrl.data;
      end else if ((MY_CNT > ins_pos) && (MY_CNT <= count)) begin
        entry <= prev_entry;
      end
    end else if (ctrl.wb && (MY_IDX == wb_idx)) begin
      entry <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.best <= take ? entry : tok_in.best;
    idx_out      <= take ? MY_IDX : idx_in;
    tok_out.last <= (MY_LAST == count) ? entry : tok_in.last;
  end

endmodule

### rtl/core/seq_list_insert_extract_min.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_list_insert_extract_min: ordered list with insert and extract-minimum
// A row of cells, one entry each. Insert shifts the upper part of the row by
// one cell; extract sends a search token through the row.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata, low bit first)
//  s_axis   in   action[1:0] position[8:2] value[40:9]
//  m_axis   out  status[1:0] removed_value[33:2] new_length[40:34]
//
//  Insert, clear and unused actions: result registered, shown in the cycle after.
//  Extract: the result waits for the token to cross every cell register.
//  One item is in work at a time; the next is taken once the result register
//  is free or being drained. Reset empties the list, no clearing pass.
// ----------------------------------------------------------------------------
module seq_list_insert_extract_min
  import slie_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // action[1:0] position[8:2] value[40:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status[1:0] removed_value[33:2] new_length[40:34]
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [1:0]    out_status;
  logic [31:0]   out_removed;
  logic [6:0]    out_len;

  logic [1:0]    action;
  logic [6:0]    position;
  logic [31:0]   value;
  logic          accept;
  logic          bad_pos;
  logic          full;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] lim_ext;
  logic          scan_done;

  cell_ctrl_t    ctrl;
  logic [CW-1:0] ins_pos;
  scan_tok_t     tok_w [CAPACITY+1];
  logic [IW-1:0] idx_w [CAPACITY+1];
  logic [31:0]   entry_w [CAPACITY];

  assign action   = s_axis_tdata[1:0];
  assign position = s_axis_tdata[8:2];
  assign value    = s_axis_tdata[40:9];

  assign s_axis_tready = !rst && (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_ext = PW'(position);
  assign lim_ext = PW'(count) + PW'(1);
  assign bad_pos = (position == 7'd0) || (pos_ext > lim_ext);
  assign full    = (count == CAP_CNT);
  assign ins_pos = CW'(pos_ext - PW'(1));

  assign scan_done = (state == S_SCAN) && tok_w[CAPACITY].vld;

  assign ctrl.ins  = accept && (action == ACT_INSERT) && !bad_pos && !full;
  assign ctrl.wb   = scan_done;
  assign ctrl.data = scan_done ? tok_w[CAPACITY].last : value;

  // launch the search token on an extract of a non-empty list
  assign tok_w[0].vld  = accept && (action == ACT_EXTRACT) && (count != '0);
  assign tok_w[0].best = '0;
  assign tok_w[0].last = '0;
  assign idx_w[0]      = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slie_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .count      (count),
      .ins_pos    (ins_pos),
      .wb_idx     (idx_w[CAPACITY]),
      .prev_entry (entry_w[(i == 0) ? 0 : i - 1]),
      .entry      (entry_w[i]),
      .tok_in     (tok_w[i]),
      .idx_in     (idx_w[i]),
      .tok_out    (tok_w[i+1]),
      .idx_out    (idx_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            out_removed <= '0;
            out_status  <= ST_OK;
            out_len     <= 7'(count);
            unique case (action)
              ACT_INSERT: begin
                m_axis_tvalid <= 1'b1;
                if (bad_pos) begin
                  out_status <= ST_BAD_POS;
                end else if (full) begin
                  out_status <= ST_FULL;
                end else begin
                  count   <= count + CW'(1);
                  out_len <= 7'(count + CW'(1));
                end
              end
              ACT_EXTRACT: begin
                if (count == '0) begin
                  m_axis_tvalid <= 1'b1;
                  out_status    <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_CLEAR: begin
                m_axis_tvalid <= 1'b1;
                count         <= '0;
                out_len       <= '0;
              end
              default: begin
                m_axis_tvalid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // token has crossed every cell: report the minimum, refill its slot
          if (scan_done) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= ST_OK;
            out_removed   <= tok_w[CAPACITY].best;
            out_len       <= 7'(count - CW'(1));
            count         <= count - CW'(1);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, out_len, out_removed, out_status};

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_token_in_scan : assert property (@(posedge clk) disable iff (rst)
    tok_w[CAPACITY].vld |-> (state == S_SCAN))
    else $error("search token arrived outside a scan");

  a_no_take_in_scan : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !s_axis_tready)
    else $error("input taken during a scan");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_CLEAR)) |=> (count == '0))
    else $error("clear left entries behind");

  a_extract_shrinks : assert property (@(posedge clk) disable iff (rst)
    scan_done |=> (count == $past(count) - CW'(1)) && m_axis_tvalid)
    else $error("extract did not shrink the list");

endmodule
